FILE: hdl/clie_pkg.sv
package clie_pkg;

	localparam int ADDR_W = 16;

	// item kinds, set by the front end
	localparam logic [1:0] K_EXEC = 2'd0;
	localparam logic [1:0] K_WR   = 2'd1;
	localparam logic [1:0] K_RD   = 2'd2;
	localparam logic [1:0] K_NOP  = 2'd3;

	// action codes of the input channel
	localparam logic [1:0] ACT_EXEC = 2'd0;
	localparam logic [1:0] ACT_WR   = 2'd1;
	localparam logic [1:0] ACT_RD   = 2'd2;

	localparam logic [2:0] R_HLM = 3'd6;
	localparam logic [15:0] HIGH_PAGE = 16'hFF00;

	localparam logic [7:0] OP_LD_A_BC   = 8'h0A;
	localparam logic [7:0] OP_LD_A_DE   = 8'h1A;
	localparam logic [7:0] OP_LD_A_NN   = 8'hFA;
	localparam logic [7:0] OP_LD_BC_A   = 8'h02;
	localparam logic [7:0] OP_LD_DE_A   = 8'h12;
	localparam logic [7:0] OP_LD_NN_A   = 8'hEA;
	localparam logic [7:0] OP_LD_A_HC   = 8'hF2;
	localparam logic [7:0] OP_LD_HC_A   = 8'hE2;
	localparam logic [7:0] OP_LDD_A_HL  = 8'h3A;
	localparam logic [7:0] OP_LDD_HL_A  = 8'h32;
	localparam logic [7:0] OP_LDI_A_HL  = 8'h2A;
	localparam logic [7:0] OP_LDI_HL_A  = 8'h22;
	localparam logic [7:0] OP_LDH_N_A   = 8'hE0;
	localparam logic [7:0] OP_LDH_A_N   = 8'hF0;
	localparam logic [7:0] OP_LD_BC_NN  = 8'h01;
	localparam logic [7:0] OP_LD_DE_NN  = 8'h11;
	localparam logic [7:0] OP_LD_HL_NN  = 8'h21;
	localparam logic [7:0] OP_LD_SP_NN  = 8'h31;
	localparam logic [7:0] OP_LD_SP_HL  = 8'hF9;
	localparam logic [7:0] OP_LDHL      = 8'hF8;
	localparam logic [7:0] OP_HALT      = 8'h76;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] address;
		logic [7:0]  data;
	} item_t;

endpackage

FILE: hdl/clie_front.sv
module clie_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	input  logic [15:0]          address,
	input  logic [7:0]           data,
	output logic                 q_valid,
	output clie_pkg::item_t      q_item,
	input  logic                 q_pop
);
	import clie_pkg::*;

	item_t      slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;

	// classify the action into an item kind
	always_comb begin
		unique case (action)
			ACT_EXEC: cls.kind = K_EXEC;
			ACT_WR:   cls.kind = K_WR;
			ACT_RD:   cls.kind = K_RD;
			default:  cls.kind = K_NOP;
		endcase
		cls.address = address;
		cls.data    = data;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

FILE: hdl/clie_back.sv
module clie_back #(
	parameter int ADDRESS_WIDTH = clie_pkg::ADDR_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  clie_pkg::item_t      q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          pc_out,
	output logic [15:0]          sp_out,
	output logic [7:0]           a_out,
	output logic [15:0]          bc_out,
	output logic [15:0]          de_out,
	output logic [15:0]          hl_out,
	output logic                 zero_flag,
	output logic                 subtract_flag,
	output logic                 half_carry_flag,
	output logic                 carry_flag,
	output logic [31:0]          cycle_total,
	output logic [7:0]           read_data
);
	import clie_pkg::*;

	localparam int DEPTH = 1 << ADDRESS_WIDTH;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_EX0  = 4'd2;
	localparam logic [3:0] S_EX1  = 4'd3;
	localparam logic [3:0] S_EX2  = 4'd4;
	localparam logic [3:0] S_EX3  = 4'd5;
	localparam logic [3:0] S_EX4  = 4'd6;
	localparam logic [3:0] S_WR   = 4'd7;
	localparam logic [3:0] S_RD   = 4'd8;
	localparam logic [3:0] S_RD2  = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic [3:0]  st_q;
	logic [ADDRESS_WIDTH-1:0] clr_q;
	item_t       it_q;
	logic [7:0]  mem_q [DEPTH];
	logic [7:0]  rdata_q;
	logic        we;
	logic [ADDRESS_WIDTH-1:0] ma;
	logic [7:0]  wd;

	logic [15:0] pc_q, sp_q, bc_q, de_q, hl_q;
	logic [7:0]  a_q, op_q, n_q, nh_q, md_q, rd_q;
	logic [3:0]  f_q;
	logic [31:0] cyc_q;
	logic        ov_q;

	logic [2:0]  src, dst;
	logic        ld_rr, ld_rn, need_rd, need_wr;
	logic [15:0] ea, nn;
	logic        out_free;

	function automatic logic [7:0] get_r(input logic [2:0] r, input logic [15:0] bc,
			input logic [15:0] de, input logic [15:0] hl, input logic [7:0] a,
			input logic [7:0] m);
		logic [7:0] v;
		unique case (r)
			3'd0: v = bc[15:8];
			3'd1: v = bc[7:0];
			3'd2: v = de[15:8];
			3'd3: v = de[7:0];
			3'd4: v = hl[15:8];
			3'd5: v = hl[7:0];
			3'd6: v = m;
			default: v = a;
		endcase
		return v;
	endfunction

	assign src   = op_q[2:0];
	assign dst   = op_q[5:3];
	// the high immediate byte is still in the read register during the access cycle
	assign nn    = {((st_q == S_EX3) ? rdata_q : nh_q), n_q};
	assign ld_rr = (op_q[7:6] == 2'b01) && (op_q != OP_HALT);
	assign ld_rn = ((op_q & 8'hC7) == 8'h06);
	assign out_free = !ov_q || out_ready;

	// decode the data access of the fetched opcode
	always_comb begin
		need_rd = 1'b0;
		need_wr = 1'b0;
		ea      = hl_q;
		wd      = a_q;
		if (ld_rr) begin
			need_rd = (src == R_HLM);
			need_wr = (dst == R_HLM);
			wd      = get_r(src, bc_q, de_q, hl_q, a_q, 8'h00);
		end else if (ld_rn) begin
			need_wr = (dst == R_HLM);
			wd      = n_q;
		end else begin
			unique case (op_q)
				OP_LD_A_BC:  begin need_rd = 1'b1; ea = bc_q; end
				OP_LD_A_DE:  begin need_rd = 1'b1; ea = de_q; end
				OP_LD_A_NN:  begin need_rd = 1'b1; ea = nn; end
				OP_LD_BC_A:  begin need_wr = 1'b1; ea = bc_q; end
				OP_LD_DE_A:  begin need_wr = 1'b1; ea = de_q; end
				OP_LD_NN_A:  begin need_wr = 1'b1; ea = nn; end
				OP_LD_A_HC:  begin need_rd = 1'b1; ea = HIGH_PAGE | {8'h00, bc_q[7:0]}; end
				OP_LD_HC_A:  begin need_wr = 1'b1; ea = HIGH_PAGE | {8'h00, bc_q[7:0]}; end
				OP_LDD_A_HL, OP_LDI_A_HL: need_rd = 1'b1;
				OP_LDD_HL_A, OP_LDI_HL_A: need_wr = 1'b1;
				OP_LDH_A_N:  begin need_rd = 1'b1; ea = HIGH_PAGE | {8'h00, n_q}; end
				OP_LDH_N_A:  begin need_wr = 1'b1; ea = HIGH_PAGE | {8'h00, n_q}; end
				default: ;
			endcase
		end
	end

	// single memory port
	always_comb begin
		we = 1'b0;
		ma = ea[ADDRESS_WIDTH-1:0];
		unique case (st_q)
			S_CLR: begin we = 1'b1; ma = clr_q; end
			S_EX0: ma = pc_q[ADDRESS_WIDTH-1:0];
			S_EX1: ma = 16'(pc_q + 16'd1);
			S_EX2: ma = 16'(pc_q + 16'd2);
			S_EX3: we = need_wr;
			S_WR, S_RD: begin we = (st_q == S_WR); ma = it_q.address; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[ma] <= (st_q == S_CLR) ? 8'h00 : (st_q == S_WR) ? it_q.data : wd;
		rdata_q <= mem_q[ma];
	end

	assign q_pop = (st_q == S_IDLE) && q_valid;

	always_ff @(posedge clk) begin
		if (q_pop) it_q <= q_item;
		if (st_q == S_EX1) op_q <= rdata_q;
		if (st_q == S_EX2) n_q  <= rdata_q;
		if (st_q == S_EX3) nh_q <= rdata_q;
		if (st_q == S_EX4 || st_q == S_RD2) md_q <= rdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_CLR;
			clr_q <= '0;
			pc_q <= '0; sp_q <= '0; bc_q <= '0; de_q <= '0; hl_q <= '0;
			a_q <= '0; f_q <= '0; cyc_q <= '0; rd_q <= '0; ov_q <= 1'b0;
		end else begin
			if (st_q == S_FIN && out_free) ov_q <= 1'b1;
			else if (ov_q && out_ready) ov_q <= 1'b0;
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) st_q <= S_IDLE;
				end
				S_IDLE: if (q_valid) begin
					unique case (q_item.kind)
						K_EXEC:  st_q <= S_EX0;
						K_WR:    st_q <= S_WR;
						K_RD:    st_q <= S_RD;
						default: st_q <= S_FIN;
					endcase
				end
				S_EX0: st_q <= S_EX1;
				S_EX1: st_q <= S_EX2;
				S_EX2: st_q <= S_EX3;
				S_EX3: st_q <= need_rd ? S_EX4 : S_FIN;
				S_EX4: st_q <= S_FIN;
				S_WR:  st_q <= S_FIN;
				S_RD:  st_q <= S_RD2;
				S_RD2: st_q <= S_FIN;
				S_FIN: if (out_free) begin
					// commit the item and present it
					st_q <= S_IDLE;
					rd_q <= (it_q.kind == K_RD) ? md_q : 8'h00;
					if (it_q.kind == K_EXEC) begin
						logic [7:0]  v;
						logic [15:0] len;
						logic [31:0] cyc;
						logic [8:0]  lo;
						v   = 8'h00;
						len = 16'd1;
						cyc = 32'd0;
						lo  = {1'b0, sp_q[7:0]} + {1'b0, n_q};
						if (ld_rr || ld_rn) begin
							v = ld_rr ? get_r(src, bc_q, de_q, hl_q, a_q, md_q) : n_q;
							unique case (dst)
								3'd0: bc_q[15:8] <= v;
								3'd1: bc_q[7:0]  <= v;
								3'd2: de_q[15:8] <= v;
								3'd3: de_q[7:0]  <= v;
								3'd4: hl_q[15:8] <= v;
								3'd5: hl_q[7:0]  <= v;
								3'd6: ;
								default: a_q <= v;
							endcase
							if (ld_rr) cyc = (dst == R_HLM || src == R_HLM) ? 32'd8 : 32'd4;
							else begin
								len = 16'd2;
								cyc = (dst == R_HLM) ? 32'd12 : 32'd8;
							end
						end else begin
							unique case (op_q)
								OP_LD_A_BC, OP_LD_A_DE, OP_LD_A_HC: begin
									a_q <= md_q; cyc = 32'd8; end
								OP_LD_A_NN: begin a_q <= md_q; len = 16'd3; cyc = 32'd16; end
								OP_LD_BC_A, OP_LD_DE_A, OP_LD_HC_A: cyc = 32'd8;
								OP_LD_NN_A: begin len = 16'd3; cyc = 32'd16; end
								OP_LDD_A_HL: begin a_q <= md_q; hl_q <= hl_q - 16'd1;
									cyc = 32'd8; end
								OP_LDI_A_HL: begin a_q <= md_q; hl_q <= hl_q + 16'd1;
									cyc = 32'd8; end
								OP_LDD_HL_A: begin hl_q <= hl_q - 16'd1; cyc = 32'd8; end
								OP_LDI_HL_A: begin hl_q <= hl_q + 16'd1; cyc = 32'd8; end
								OP_LDH_N_A: begin len = 16'd2; cyc = 32'd12; end
								OP_LDH_A_N: begin a_q <= md_q; len = 16'd2; cyc = 32'd12; end
								OP_LD_BC_NN: begin bc_q <= nn; len = 16'd3; cyc = 32'd12; end
								OP_LD_DE_NN: begin de_q <= nn; len = 16'd3; cyc = 32'd12; end
								OP_LD_HL_NN: begin hl_q <= nn; len = 16'd3; cyc = 32'd12; end
								OP_LD_SP_NN: begin sp_q <= nn; len = 16'd3; cyc = 32'd12; end
								OP_LD_SP_HL: begin sp_q <= hl_q; cyc = 32'd8; end
								OP_LDHL: begin
									hl_q <= sp_q + {{8{n_q[7]}}, n_q};
									f_q  <= {2'b00,
										(({1'b0, sp_q[3:0]} + {1'b0, n_q[3:0]}) > 5'h0F), lo[8]};
									len = 16'd2;
									cyc = 32'd12;
								end
								default: ;
							endcase
						end
						pc_q  <= pc_q + len;
						cyc_q <= cyc_q + cyc;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = ov_q;
	assign pc_out          = pc_q;
	assign sp_out          = sp_q;
	assign a_out           = a_q;
	assign bc_out          = bc_q;
	assign de_out          = de_q;
	assign hl_out          = hl_q;
	assign zero_flag       = f_q[3];
	assign subtract_flag   = f_q[2];
	assign half_carry_flag = f_q[1];
	assign carry_flag      = f_q[0];
	assign cycle_total     = cyc_q;
	assign read_data       = rd_q;
endmodule

FILE: hdl/cpu_load_instruction_executor_core.sv
// Load-instruction executor with a private 64 KiB byte memory. Each input beat is an
// action: execute the load instruction at PC, write one memory byte, or read one.
// Each result beat reports PC, SP, A, BC, DE, HL, the four flags, the running
// clock-cycle total and the byte read (zero unless the beat was a read).
// After reset the memory is cleared one byte per clock, so no beat is taken by the
// executor until every byte is cleared (two beats may still queue at the input).
// A beat then runs through steps on the single memory port: execute is dispatch,
// three opcode/immediate fetches, the data access, a capture of read data when it
// reads memory, and a commit; write is dispatch, write, commit; read adds a capture;
// an unused action is dispatch and commit. A two-entry input queue keeps accepting
// while a result beat waits at the output register.
module cpu_load_instruction_executor_core #(
	parameter int ADDRESS_WIDTH = clie_pkg::ADDR_W
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pc_out,
	output logic [15:0] sp_out,
	output logic [7:0]  a_out,
	output logic [15:0] bc_out,
	output logic [15:0] de_out,
	output logic [15:0] hl_out,
	output logic        zero_flag,
	output logic        subtract_flag,
	output logic        half_carry_flag,
	output logic        carry_flag,
	output logic [31:0] cycle_total,
	output logic [7:0]  read_data
);
	import clie_pkg::*;

	logic  q_valid, q_pop;
	item_t q_item;

	// front: accept and classify beats into the queue
	clie_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .action, .address, .data,
		.q_valid, .q_item, .q_pop
	);

	// back: sequence memory accesses and commit architectural state
	clie_back #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_back (
		.clk, .arst_n, .q_valid, .q_item, .q_pop, .out_valid, .out_ready,
		.pc_out, .sp_out, .a_out, .bc_out, .de_out, .hl_out,
		.zero_flag, .subtract_flag, .half_carry_flag, .carry_flag,
		.cycle_total, .read_data
	);
endmodule
